// File: rtl/local_extremum_3x3_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// local extremum 3x3 detector assertion macros
// concurrent checks on clk with reset disable, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef LOCAL_EXTREMUM_3X3_DETECTOR_UNIT_ASSERT_SVH
`define LOCAL_EXTREMUM_3X3_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTH

`define LEXT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("local extremum unit: check failed");

`define LEXT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("local extremum unit: forbidden condition");

`else

`define LEXT_ASSERT(lbl, prop)

`define LEXT_NEVER(lbl, expr)

`endif

`endif

// File: rtl/lext3_pkg.sv
// ----------------------------------------------------------------------------
// lext3_pkg
// shared types and constants of the 3x3 local extremum detector
// ----------------------------------------------------------------------------
package lext3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [PIX_W-1:0] pix_t;

    localparam pix_t PIX_MIN = 8'h00;
    localparam pix_t PIX_MAX = 8'hFF;

    localparam logic [FW_W-1:0]  RST_WIDTH     = 11'd640;
    localparam logic [FH_W-1:0]  RST_HEIGHT    = 16'd480;
    localparam pix_t             RST_THRESHOLD = 8'd0;

    localparam logic CONN_4   = 1'b0;
    localparam logic CONN_8   = 1'b1;
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH     = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_THRESHOLD = 3'd2,
        REG_CONNECT   = 3'd3,
        REG_KIND      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        pix_t threshold;
        logic connectivity;
        logic kind;
    } mode_t;

    // set bit: neighbours on that side lie outside the frame
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } border_t;

    typedef struct packed {
        pix_t pixel_out;
        logic is_extremum;
        logic last_of_run;
        logic frame_end;
    } result_t;

endpackage

// File: rtl/lext3_judge.sv
// ----------------------------------------------------------------------------
// lext3_judge
// threshold and neighbour test of one window centre
// ----------------------------------------------------------------------------
module lext3_judge (
    input  lext3_pkg::mode_t         mode,
    input  lext3_pkg::border_t       border,
    input  lext3_pkg::pix_t    [2:0] col_l,     // [0] top, [1] middle, [2] bottom
    input  lext3_pkg::pix_t    [2:0] col_c,
    input  lext3_pkg::pix_t    [2:0] col_r,
    output lext3_pkg::pix_t          pixel_out,
    output logic                     is_extremum
);
    import lext3_pkg::*;

    pix_t          v;
    pix_t    [7:0] nb;
    logic    [7:0] nb_en;
    logic          diag;
    logic          ok;

    always_comb
    begin
        v    = col_c[1];
        diag = (mode.connectivity == CONN_8);

        // up-left, up, up-right, left, right, down-left, down, down-right
        nb[0] = col_l[0];
        nb[1] = col_c[0];
        nb[2] = col_r[0];
        nb[3] = col_l[1];
        nb[4] = col_r[1];
        nb[5] = col_l[2];
        nb[6] = col_c[2];
        nb[7] = col_r[2];

        nb_en[0] = diag & !border.top & !border.left;
        nb_en[1] = !border.top;
        nb_en[2] = diag & !border.top & !border.right;
        nb_en[3] = !border.left;
        nb_en[4] = !border.right;
        nb_en[5] = diag & !border.bottom & !border.left;
        nb_en[6] = !border.bottom;
        nb_en[7] = diag & !border.bottom & !border.right;

        if (mode.kind == KIND_MIN)
            ok = (v <= mode.threshold);
        else
            ok = (v >= mode.threshold);

        for (int i = 0; i < 8; i++)
        begin
            if (nb_en[i])
            begin
                if (mode.kind == KIND_MIN)
                begin
                    if (nb[i] < v)
                        ok = 1'b0;
                end
                else
                begin
                    if (nb[i] > v)
                        ok = 1'b0;
                end
            end
        end

        is_extremum = ok;
        if (ok)
            pixel_out = v;
        else if (mode.kind == KIND_MIN)
            pixel_out = PIX_MAX;
        else
            pixel_out = PIX_MIN;
    end

endmodule

// File: rtl/local_extremum_3x3_detector_unit.sv
// ----------------------------------------------------------------------------
// local_extremum_3x3_detector_unit: 3x3 non-maximum / non-minimum suppression
// path: the input word that completes a result passes stage 1 and stage 2 into the result queue
// throughput: one pixel per clock while s_tready is high, set by the single line memory port pair
// s_tready drops only while the 4-entry result queue holds 3 or more words
// reset: counters, window, pipeline and queue cleared; line memory not cleared
// ----------------------------------------------------------------------------
`include "local_extremum_3x3_detector_unit_assert.svh"

module local_extremum_3x3_detector_unit #(
    parameter int MAX_WIDTH = lext3_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [lext3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lext3_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,     // [7:0] pixel_in
    input  logic [0:0]                        s_tuser,     // [0] pad

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,     // [7:0] pixel_out
    output logic [1:0]                        m_tuser,     // [0] is_extremum, [1] frame_end
    output logic                              m_tlast      // last_of_run
);
    import lext3_pkg::*;

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int WW      = (CW > FW_W) ? CW : FW_W;
    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    // configuration registers
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    pix_t            thr_reg;
    logic            conn_reg;
    logic            kind_reg;
    mode_t           mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            thr_reg    <= RST_THRESHOLD;
            conn_reg   <= CONN_4;
            kind_reg   <= KIND_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:     width_reg  <= cfg_data[FW_W-1:0];
                REG_HEIGHT:    height_reg <= cfg_data[FH_W-1:0];
                REG_THRESHOLD: thr_reg    <= cfg_data[PIX_W-1:0];
                REG_CONNECT:   conn_reg   <= cfg_data[0];
                REG_KIND:      kind_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign mode = '{threshold: thr_reg, connectivity: conn_reg, kind: kind_reg};

    // effective frame size
    logic [WW-1:0]   fw_ext;
    logic [CW-1:0]   w_eff;
    logic [FH_W-1:0] h_eff;

    assign fw_ext = WW'(width_reg);

    always_comb
    begin
        if (width_reg == '0)
            w_eff = CW'(1);
        else if (fw_ext > WW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(fw_ext);
        h_eff = (height_reg == '0) ? FH_W'(1) : height_reg;
    end

    // handshake and pipeline advance
    logic [QCW-1:0] q_count_reg;
    logic           adv;
    logic           s_acc;

    assign adv      = (q_count_reg <= QCW'(Q_DEPTH - 2));
    assign s_tready = adv;
    assign s_acc    = s_tvalid & adv;

    // position counters
    logic [AW-1:0]   col_reg;
    logic [AW-1:0]   col_next;
    logic [FH_W-1:0] row_reg;
    logic [FH_W-1:0] row_next;
    logic [AW-1:0]   cur_col;
    logic [FH_W-1:0] cur_row;
    logic            restart;
    logic            row_end;
    pix_t            cur_pix;

    always_comb
    begin
        restart = (CW'(col_reg) >= w_eff) || (row_reg > h_eff);
        cur_col = restart ? '0 : col_reg;
        cur_row = restart ? '0 : row_reg;
        row_end = ((CW'(cur_col) + CW'(1)) == w_eff);
        cur_pix = s_tuser[0] ? PIX_MIN : s_tdata;
        if (row_end)
        begin
            col_next = '0;
            row_next = (cur_row >= h_eff) ? '0 : cur_row + FH_W'(1);
        end
        else
        begin
            col_next = cur_col + AW'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line memory data back, write-back and window shift
    logic              s1_valid_reg;
    logic [AW-1:0]     s1_c_reg;
    logic [FH_W-1:0]   s1_r_reg;
    pix_t              s1_p_reg;
    logic              s1_fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] line_rd;
    logic [2*PIX_W-1:0] mem_wdata;
    logic              mem_we;
    pix_t              up2;
    pix_t              up1;

    // entry: [15:8] row two above, [7:0] row above
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    assign mem_we    = s1_valid_reg & adv;
    assign line_rd   = s1_fwd_reg ? fwd_data_reg : rd_data_reg;
    assign up2       = line_rd[2*PIX_W-1:PIX_W];
    assign up1       = line_rd[PIX_W-1:0];
    assign mem_wdata = {up1, s1_p_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[s1_c_reg] <= mem_wdata;
        if (s_acc)
            rd_data_reg <= line_mem[cur_col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_acc;
            s1_fwd_reg   <= mem_we && (s1_c_reg == cur_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_c_reg <= cur_col;
            s1_r_reg <= cur_row;
            s1_p_reg <= cur_pix;
        end
        if (mem_we)
            fwd_data_reg <= mem_wdata;
    end

    pix_t [2:0] col0_reg;
    pix_t [2:0] col1_reg;
    pix_t [2:0] col2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col0_reg <= '0;
            col1_reg <= '0;
            col2_reg <= '0;
        end
        else if (mem_we)
        begin
            col0_reg <= col1_reg;
            col1_reg <= col2_reg;
            col2_reg <= {s1_p_reg, up1, up2};
        end
    end

    // stage 2: judge the centres and queue the results
    logic            s2_valid_reg;
    logic [AW-1:0]   s2_c_reg;
    logic [FH_W-1:0] s2_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            s2_c_reg <= s1_c_reg;
            s2_r_reg <= s1_r_reg;
        end
    end

    logic    has_a;
    logic    has_b;
    logic    at_bottom;
    border_t border_a;
    border_t border_b;
    pix_t    pix_a;
    pix_t    pix_b;
    logic    ext_a;
    logic    ext_b;
    result_t res_a;
    result_t res_b;

    always_comb
    begin
        has_a     = s2_valid_reg && (s2_r_reg != '0) && (s2_c_reg != '0);
        has_b     = s2_valid_reg && (s2_r_reg != '0)
                    && ((CW'(s2_c_reg) + CW'(1)) == w_eff);
        at_bottom = (s2_r_reg == h_eff);

        border_a.left   = (s2_c_reg == AW'(1));
        border_a.right  = 1'b0;
        border_a.top    = (s2_r_reg == FH_W'(1));
        border_a.bottom = at_bottom;

        border_b.left   = (s2_c_reg == '0);
        border_b.right  = 1'b1;
        border_b.top    = (s2_r_reg == FH_W'(1));
        border_b.bottom = at_bottom;
    end

    lext3_judge u_judge_a (
        .mode        (mode),
        .border      (border_a),
        .col_l       (col0_reg),
        .col_c       (col1_reg),
        .col_r       (col2_reg),
        .pixel_out   (pix_a),
        .is_extremum (ext_a)
    );

    lext3_judge u_judge_b (
        .mode        (mode),
        .border      (border_b),
        .col_l       (col1_reg),
        .col_c       (col2_reg),
        .col_r       (col2_reg),
        .pixel_out   (pix_b),
        .is_extremum (ext_b)
    );

    assign res_a = '{pixel_out: pix_a, is_extremum: ext_a, last_of_run: !has_b,
                     frame_end: 1'b0};
    assign res_b = '{pixel_out: pix_b, is_extremum: ext_b, last_of_run: 1'b1,
                     frame_end: at_bottom};

    // result queue
    result_t        q_mem [Q_DEPTH];
    logic [QAW-1:0] head_reg;
    logic [QAW-1:0] tail_reg;
    logic [1:0]     push_n;
    logic           pop;

    assign push_n = adv ? ({1'b0, has_a} + {1'b0, has_b}) : 2'd0;
    assign pop    = m_tvalid & m_tready;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (has_a)
            begin
                q_mem[tail_reg] <= res_a;
                if (has_b)
                    q_mem[tail_reg + QAW'(1)] <= res_b;
            end
            else if (has_b)
                q_mem[tail_reg] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            tail_reg    <= tail_reg + QAW'(push_n);
            head_reg    <= head_reg + QAW'(pop);
            q_count_reg <= q_count_reg + QCW'(push_n) - QCW'(pop);
        end
    end

    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = q_mem[head_reg].pixel_out;
    assign m_tuser  = {q_mem[head_reg].frame_end, q_mem[head_reg].is_extremum};
    assign m_tlast  = q_mem[head_reg].last_of_run;

    // checks
    `LEXT_ASSERT(a_q_bound, q_count_reg <= QCW'(Q_DEPTH))
    `LEXT_ASSERT(a_frame_end_last, m_tvalid && m_tuser[1] |-> m_tlast)
    `LEXT_ASSERT(a_s1_hold, s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_c_reg))
    `LEXT_NEVER(a_push_full, (push_n != 2'd0) && (q_count_reg > QCW'(Q_DEPTH - 2)))

endmodule
